>>> hdl/spinj_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spinj_pkg
// Shared types, constants and helpers for the stream pattern injector.
// ---------------------------------------------------------------------------
package spinj_pkg;

    localparam int KEY_BYTES_MAX = 8;
    localparam int KEY_W         = 8 * KEY_BYTES_MAX;
    localparam int LEN_W         = 4;
    localparam int CNT_W         = 17;
    localparam int IDX_W         = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_KEY_BYTES       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_KEY_LENGTH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_KEY_BYTES      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_KEY_LENGTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INJECT_PATTERN_BYTES  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INJECT_PATTERN_LENGTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INJECT_COUNT          = 3'd6;

    // reset values: "Host:", CR, " " CR, 65536 bytes
    localparam logic [KEY_W-1:0] RST_FIRST_KEY_BYTES       = 64'h0000_003A_7473_6F48;
    localparam logic [LEN_W-1:0] RST_FIRST_KEY_LENGTH      = 4'd5;
    localparam logic [KEY_W-1:0] RST_SECOND_KEY_BYTES      = 64'h0000_0000_0000_000D;
    localparam logic [LEN_W-1:0] RST_SECOND_KEY_LENGTH     = 4'd1;
    localparam logic [KEY_W-1:0] RST_INJECT_PATTERN_BYTES  = 64'h0000_0000_0000_0D20;
    localparam logic [LEN_W-1:0] RST_INJECT_PATTERN_LENGTH = 4'd2;
    localparam logic [CNT_W-1:0] RST_INJECT_COUNT          = 17'h1_0000;

    typedef struct packed {
        logic [KEY_W-1:0] first_key_bytes;
        logic [LEN_W-1:0] first_key_length;
        logic [KEY_W-1:0] second_key_bytes;
        logic [LEN_W-1:0] second_key_length;
        logic [KEY_W-1:0] inject_pattern_bytes;
        logic [LEN_W-1:0] inject_pattern_length;
        logic [CNT_W-1:0] inject_count;
    } cfg_t;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       consumed;
    } res_t;

    typedef enum logic [3:0] {
        MODE_SEARCH1 = 4'b0001,
        MODE_SEARCH2 = 4'b0010,
        MODE_INJECT  = 4'b0100,
        MODE_HELD    = 4'b1000
    } mode_t;

    // zero acts as one, anything above the key size is clipped
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] r;
        if (len == '0)
            r = LEN_W'(1);
        else if (len > LEN_W'(KEY_BYTES_MAX))
            r = LEN_W'(KEY_BYTES_MAX);
        else
            r = len;
        return r;
    endfunction

    function automatic logic [7:0] byte_at(input logic [KEY_W-1:0] bytes,
                                           input logic [IDX_W-1:0] idx);
        return bytes[8*idx +: 8];
    endfunction

endpackage

>>> hdl/spinj_cfg_regs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spinj_cfg_regs
// Configuration register file, written through a plain write port.
// ---------------------------------------------------------------------------
module spinj_cfg_regs
    import spinj_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_key_bytes       <= RST_FIRST_KEY_BYTES;
            cfg_reg.first_key_length      <= RST_FIRST_KEY_LENGTH;
            cfg_reg.second_key_bytes      <= RST_SECOND_KEY_BYTES;
            cfg_reg.second_key_length     <= RST_SECOND_KEY_LENGTH;
            cfg_reg.inject_pattern_bytes  <= RST_INJECT_PATTERN_BYTES;
            cfg_reg.inject_pattern_length <= RST_INJECT_PATTERN_LENGTH;
            cfg_reg.inject_count          <= RST_INJECT_COUNT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FIRST_KEY_BYTES:       cfg_reg.first_key_bytes       <= cfg_data;
                REG_FIRST_KEY_LENGTH:      cfg_reg.first_key_length      <= cfg_data[LEN_W-1:0];
                REG_SECOND_KEY_BYTES:      cfg_reg.second_key_bytes      <= cfg_data;
                REG_SECOND_KEY_LENGTH:     cfg_reg.second_key_length     <= cfg_data[LEN_W-1:0];
                REG_INJECT_PATTERN_BYTES:  cfg_reg.inject_pattern_bytes  <= cfg_data;
                REG_INJECT_PATTERN_LENGTH: cfg_reg.inject_pattern_length <= cfg_data[LEN_W-1:0];
                REG_INJECT_COUNT:          cfg_reg.inject_count          <= cfg_data[CNT_W-1:0];
                default:                   ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/spinj_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spinj_core
// Slot engine: key matching, pattern injection and held byte, one slot per step.
// ---------------------------------------------------------------------------
module spinj_core
    import spinj_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       step,
    input  logic       src_valid,
    input  logic [7:0] src_byte,
    output res_t       res
);

    mode_t            mode_reg, mode_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] pidx_reg, pidx_next;
    logic [7:0]       held_reg, held_next;

    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] key_len;
    logic [LEN_W-1:0] pat_len;
    logic [CNT_W-1:0] total;
    logic [IDX_W-1:0] m_idx;
    logic [LEN_W-1:0] m_idx_inc;
    logic             hit;
    logic             done;
    logic             trig;
    logic [IDX_W-1:0] p_in;
    logic [IDX_W-1:0] p_idx;
    logic [LEN_W-1:0] p_inc;
    logic [IDX_W-1:0] p_nxt;
    logic [CNT_W-1:0] c_in;
    logic [CNT_W-1:0] c_inc;
    logic             inj_end;
    logic [7:0]       inj_byte;

    // key matching, shared by both search modes
    always_comb
    begin
        key       = (mode_reg == MODE_SEARCH1) ? cfg.first_key_bytes : cfg.second_key_bytes;
        key_len   = eff_len((mode_reg == MODE_SEARCH1) ? cfg.first_key_length
                                                       : cfg.second_key_length);
        // stale index after a length change restarts at zero
        m_idx     = (cnt_reg >= CNT_W'(key_len)) ? '0 : cnt_reg[IDX_W-1:0];
        m_idx_inc = LEN_W'(m_idx) + LEN_W'(1);
        hit       = (src_byte == byte_at(key, m_idx));
        done      = hit && (m_idx_inc == key_len);
    end

    // injection step; a trigger starts from a fresh count and pattern position
    always_comb
    begin
        pat_len  = eff_len(cfg.inject_pattern_length);
        total    = (cfg.inject_count == '0) ? CNT_W'(1) : cfg.inject_count;
        trig     = (mode_reg == MODE_SEARCH2) && done;
        p_in     = trig ? '0 : pidx_reg;
        c_in     = trig ? '0 : cnt_reg;
        p_idx    = (LEN_W'(p_in) >= pat_len) ? '0 : p_in;
        p_inc    = LEN_W'(p_idx) + LEN_W'(1);
        p_nxt    = (p_inc >= pat_len) ? '0 : p_inc[IDX_W-1:0];
        inj_byte = byte_at(cfg.inject_pattern_bytes, p_idx);
        c_inc    = c_in + CNT_W'(1);
        inj_end  = (c_inc >= total);
    end

    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        pidx_next = pidx_reg;
        held_next = held_reg;
        res       = '0;
        unique case (mode_reg)
            MODE_SEARCH1:
            begin
                if (src_valid)
                begin
                    res.out_valid = 1'b1;
                    res.consumed  = 1'b1;
                    res.out_byte  = src_byte;
                    cnt_next      = (hit && !done) ? CNT_W'(m_idx_inc) : '0;
                    if (done)
                        mode_next = MODE_SEARCH2;
                end
            end
            MODE_SEARCH2:
            begin
                if (src_valid)
                begin
                    res.out_valid = 1'b1;
                    res.consumed  = 1'b1;
                    if (done)
                    begin
                        held_next    = src_byte;
                        res.out_byte = inj_byte;
                        pidx_next    = p_nxt;
                        cnt_next     = c_inc;
                        mode_next    = inj_end ? MODE_HELD : MODE_INJECT;
                    end
                    else
                    begin
                        res.out_byte = src_byte;
                        cnt_next     = hit ? CNT_W'(m_idx_inc) : '0;
                    end
                end
            end
            MODE_INJECT:
            begin
                res.out_valid = 1'b1;
                res.out_byte  = inj_byte;
                pidx_next     = p_nxt;
                cnt_next      = c_inc;
                if (inj_end)
                    mode_next = MODE_HELD;
            end
            default:
            begin
                res.out_valid = 1'b1;
                res.out_byte  = held_reg;
                mode_next     = MODE_SEARCH1;
                cnt_next      = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SEARCH1;
            cnt_reg  <= '0;
            pidx_reg <= '0;
            held_reg <= '0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            pidx_reg <= pidx_next;
            held_reg <= held_next;
        end
    end

endmodule

>>> hdl/stream_pattern_injector.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stream_pattern_injector
// Byte stream pass-through that injects a repeating pattern after two keys.
// ---------------------------------------------------------------------------
// Each input transaction is one output slot and yields exactly one result
// transaction. Source bytes are copied through while the block looks for the
// first key and then the second key; the byte completing the second key is
// held back and the pattern starts in its slot; inject_count pattern bytes
// go out in all, later ones taking no source byte, then the held byte. One
// transaction is taken per clock while the result register is not stalled;
// the slot logic between the input register and the result register is a
// byte compare, a 17-bit counter and small muxes. Configuration writes must
// be made only while no transaction is in flight; this is not enforced.
module stream_pattern_injector
    import spinj_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  src_valid,
    input  logic [7:0]            src_byte,
    // result channel
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic                  out_valid,
    output logic [7:0]            out_byte,
    output logic                  consumed
);

    cfg_t       cfg;
    res_t       res;

    // input register
    logic       item_full_reg;
    logic       item_src_valid_reg;
    logic [7:0] item_src_byte_reg;

    // result register
    logic       res_full_reg;
    res_t       res_data_reg;

    logic       res_free;
    logic       step;
    logic       in_take;

    spinj_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // result register can load when empty or being drained this cycle
    assign res_free = !res_full_reg || !res_stall;
    // slot is processed as it moves from the input register to the result
    assign step     = item_full_reg && res_free;
    // input register accepts while empty or while its item moves on
    assign in_stall = item_full_reg && !res_free;
    assign in_take  = in_valid && !in_stall;

    spinj_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (step),
        .src_valid (item_src_valid_reg),
        .src_byte  (item_src_byte_reg),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_full_reg <= 1'b0;
            res_full_reg  <= 1'b0;
        end
        else
        begin
            if (in_take)
                item_full_reg <= 1'b1;
            else if (step)
                item_full_reg <= 1'b0;

            if (step)
                res_full_reg <= 1'b1;
            else if (!res_stall)
                res_full_reg <= 1'b0;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_src_valid_reg <= src_valid;
            item_src_byte_reg  <= src_byte;
        end
        if (step)
            res_data_reg <= res;
    end

    assign res_valid = res_full_reg;
    assign out_valid = res_data_reg.out_valid;
    assign out_byte  = res_data_reg.out_byte;
    assign consumed  = res_data_reg.consumed;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stream pattern injector.
// ---------------------------------------------------------------------------
// Every input transaction is one output slot. The bench offers slots with
// random gaps, predicts each slot's outcome with its own model of the search
// and injection state and compares every result transaction, field by field,
// in order. It opens with a short table of directed slots: reset behaviour,
// byte extremes, both searches, injection, the held byte, out-of-range
// lengths, a zero inject count and stale indexes left by register changes.
// Randomised phases with mostly well-formed key sequences follow, and then
// one long injection with a full-width second key and no gaps on either side.
// ---------------------------------------------------------------------------
module tb_top;
    import spinj_pkg::*;

    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int HOLD_OFF_AT     = 150;
    localparam int RANDOM_PHASES   = 8;
    localparam int PRINT_LIMIT     = 50;

    localparam cfg_t CFG_AT_RESET = {RST_FIRST_KEY_BYTES, RST_FIRST_KEY_LENGTH,
                                     RST_SECOND_KEY_BYTES, RST_SECOND_KEY_LENGTH,
                                     RST_INJECT_PATTERN_BYTES, RST_INJECT_PATTERN_LENGTH,
                                     RST_INJECT_COUNT};

    // one directed slot; want is only used where known is set
    typedef struct {
        int         ph;
        bit         sv;
        logic [7:0] sb;
        bit         known;
        res_t       want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  src_valid;
    logic [7:0]            src_byte;
    logic                  res_valid;
    logic                  res_stall;
    logic                  out_valid;
    logic [7:0]            out_byte;
    logic                  consumed;

    // predictor state: mirror of the registers and of the slot state
    cfg_t             cfg_now   = CFG_AT_RESET;
    mode_t            st_mode   = MODE_SEARCH1;
    logic [CNT_W-1:0] run_count = '0;   // match index while searching, bytes sent while injecting
    logic [IDX_W-1:0] fill_pos  = '0;
    logic [7:0]       held_src  = '0;
    int               held_count = 0;

    res_t slot_forecast [$];
    int   fail_count   = 0;
    bit   no_gaps      = 1'b0;
    bit   narrow_bytes = 1'b0;

    // directed slots, grouped by register setting
    stim_row_t stim_table [0:23] = '{
        // reset setting: nothing offered, byte extremes
        '{0, 1'b0, 8'hFF, 1'b1, {1'b0, 8'h00, 1'b0}},
        '{0, 1'b1, 8'h00, 1'b1, {1'b1, 8'h00, 1'b1}},
        '{0, 1'b1, 8'hFF, 1'b1, {1'b1, 8'hFF, 1'b1}},
        // "Hos", an empty slot mid-match, "t:" completes the first key
        '{0, 1'b1, 8'h48, 1'b0, '0},
        '{0, 1'b1, 8'h6F, 1'b0, '0},
        '{0, 1'b1, 8'h73, 1'b0, '0},
        '{0, 1'b0, 8'hAA, 1'b0, '0},
        '{0, 1'b1, 8'h74, 1'b0, '0},
        '{0, 1'b1, 8'h3A, 1'b0, '0},
        // a miss on the second key, then CR starts the injection
        '{0, 1'b1, 8'h78, 1'b0, '0},
        '{0, 1'b1, 8'h0D, 1'b0, '0},
        // byte offered while injecting is refused
        '{0, 1'b1, 8'h51, 1'b0, '0},
        // count now zero and already passed: last fill byte, then the held byte
        '{1, 1'b0, 8'h00, 1'b0, '0},
        '{1, 1'b1, 8'h41, 1'b0, '0},
        // zero first key length, oversized second key and pattern lengths
        '{2, 1'b1, 8'hFF, 1'b0, '0},
        '{2, 1'b1, 8'h01, 1'b0, '0},
        '{2, 1'b1, 8'h02, 1'b0, '0},
        '{2, 1'b1, 8'h03, 1'b0, '0},
        // second key shortened below the match index
        '{3, 1'b1, 8'h01, 1'b0, '0},
        '{3, 1'b1, 8'h02, 1'b0, '0},
        '{3, 1'b0, 8'h00, 1'b0, '0},
        '{3, 1'b1, 8'h5A, 1'b0, '0},
        // pattern shortened below the pattern index
        '{4, 1'b0, 8'h00, 1'b0, '0},
        '{4, 1'b1, 8'hC3, 1'b0, '0}
    };

    stream_pattern_injector uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .src_valid (src_valid),
        .src_byte  (src_byte),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .consumed  (consumed)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // zero behaves as one, anything above the key size is clipped
    function automatic int usable_len(input logic [LEN_W-1:0] len_reg);
        if (len_reg == '0)
            return 1;
        if (len_reg > LEN_W'(KEY_BYTES_MAX))
            return KEY_BYTES_MAX;
        return int'(len_reg);
    endfunction

    // naive match: a miss restarts at zero, the missed byte is not retried
    function automatic bit key_advance(input logic [KEY_W-1:0] key,
                                       input logic [LEN_W-1:0] len_reg,
                                       input logic [7:0] c);
        int len;
        int pos;
        len = usable_len(len_reg);
        pos = (run_count >= len) ? 0 : int'(run_count);
        if (c != key[8*pos +: 8])
        begin
            run_count = '0;
            return 1'b0;
        end
        pos++;
        run_count = (pos == len) ? '0 : CNT_W'(pos);
        return pos == len;
    endfunction

    function automatic logic [7:0] next_fill_byte();
        int               plen;
        logic [CNT_W-1:0] total;
        logic [7:0]       b;
        plen  = usable_len(cfg_now.inject_pattern_length);
        total = (cfg_now.inject_count == '0) ? CNT_W'(1) : cfg_now.inject_count;
        if (fill_pos >= plen)
            fill_pos = '0;
        b        = cfg_now.inject_pattern_bytes[8*fill_pos +: 8];
        fill_pos = (int'(fill_pos) + 1 >= plen) ? '0 : fill_pos + 1'b1;
        run_count = run_count + 1'b1;
        // a count left above a lowered limit also ends the injection
        if (run_count >= total)
            st_mode = MODE_HELD;
        return b;
    endfunction

    function automatic res_t predict_slot(input logic sv, input logic [7:0] sb);
        res_t r;
        r = '0;
        case (st_mode)
            MODE_SEARCH1:
            begin
                if (sv)
                begin
                    r = {1'b1, sb, 1'b1};
                    if (key_advance(cfg_now.first_key_bytes, cfg_now.first_key_length, sb))
                        st_mode = MODE_SEARCH2;
                end
            end
            MODE_SEARCH2:
            begin
                if (sv)
                begin
                    r = {1'b1, sb, 1'b1};
                    if (key_advance(cfg_now.second_key_bytes, cfg_now.second_key_length, sb))
                    begin
                        // trigger byte is held back, first fill byte takes its slot
                        held_src   = sb;
                        run_count  = '0;
                        fill_pos   = '0;
                        st_mode    = MODE_INJECT;
                        r.out_byte = next_fill_byte();
                    end
                end
            end
            MODE_INJECT:
            begin
                r.out_valid = 1'b1;
                r.out_byte  = next_fill_byte();
            end
            default:
            begin
                r.out_valid = 1'b1;
                r.out_byte  = held_src;
                st_mode     = MODE_SEARCH1;
                run_count   = '0;
                held_count++;
            end
        endcase
        return r;
    endfunction

    // byte that would move the current search one step on
    function automatic logic [7:0] wanted_byte();
        logic [KEY_W-1:0] key;
        int               len;
        int               pos;
        if (st_mode == MODE_SEARCH1)
        begin
            key = cfg_now.first_key_bytes;
            len = usable_len(cfg_now.first_key_length);
        end
        else
        begin
            key = cfg_now.second_key_bytes;
            len = usable_len(cfg_now.second_key_length);
        end
        pos = (run_count >= len) ? 0 : int'(run_count);
        return key[8*pos +: 8];
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [7:0] any_byte();
        if (narrow_bytes)
            return 8'h40 | 8'($urandom_range(1));
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [LEN_W-1:0] any_len();
        case ($urandom_range(9))
            0:       return 4'd0;
            1:       return 4'($urandom_range(15, 9));
            2:       return 4'd8;
            default: return 4'($urandom_range(4, 1));
        endcase
    endfunction

    function automatic cfg_t random_setting();
        cfg_t c;
        for (int i = 0; i < KEY_BYTES_MAX; i++)
        begin
            c.first_key_bytes[8*i +: 8]  = any_byte();
            c.second_key_bytes[8*i +: 8] = any_byte();
        end
        c.first_key_length      = any_len();
        c.second_key_length     = any_len();
        c.inject_pattern_bytes  = {$urandom, $urandom};
        c.inject_pattern_length = any_len();
        case ($urandom_range(9))
            0:       c.inject_count = '0;
            1:       c.inject_count = 17'd1;
            2:       c.inject_count = 17'($urandom_range(64, 13));
            default: c.inject_count = 17'($urandom_range(12, 2));
        endcase
        return c;
    endfunction

    function automatic cfg_t directed_setting(input int ph);
        cfg_t c;
        c = CFG_AT_RESET;
        if (ph == 1)
            c.inject_count = '0;
        else
        begin
            c.first_key_bytes       = 64'h0000_0000_0000_00FF;
            c.first_key_length      = 4'd0;
            c.second_key_bytes      = 64'h0807_0605_0403_0201;
            c.second_key_length     = (ph == 2) ? 4'd12 : 4'd2;
            c.inject_pattern_bytes  = 64'hA7A6_A5A4_A3A2_A1A0;
            c.inject_pattern_length = (ph == 4) ? 4'd2 : 4'd9;
            c.inject_count          = (ph == 4) ? 17'd4 : 17'd10;
        end
        return c;
    endfunction

    // writes all seven registers back to back; junk fills the unused upper bits
    task automatic program_regs(input cfg_t c, input bit junk);
        logic [CFG_DATA_W-1:0] pad;
        pad       = junk ? {$urandom, $urandom} : '0;
        cfg_we    <= 1'b1;
        cfg_index <= REG_FIRST_KEY_BYTES;
        cfg_data  <= c.first_key_bytes;
        @(posedge clk);
        cfg_index <= REG_FIRST_KEY_LENGTH;
        cfg_data  <= {pad[CFG_DATA_W-1:LEN_W], c.first_key_length};
        @(posedge clk);
        cfg_index <= REG_SECOND_KEY_BYTES;
        cfg_data  <= c.second_key_bytes;
        @(posedge clk);
        cfg_index <= REG_SECOND_KEY_LENGTH;
        cfg_data  <= {pad[CFG_DATA_W-1:LEN_W], c.second_key_length};
        @(posedge clk);
        cfg_index <= REG_INJECT_PATTERN_BYTES;
        cfg_data  <= c.inject_pattern_bytes;
        @(posedge clk);
        cfg_index <= REG_INJECT_PATTERN_LENGTH;
        cfg_data  <= {pad[CFG_DATA_W-1:LEN_W], c.inject_pattern_length};
        @(posedge clk);
        cfg_index <= REG_INJECT_COUNT;
        cfg_data  <= {pad[CFG_DATA_W-1:CNT_W], c.inject_count};
        @(posedge clk);
        cfg_we  <= 1'b0;
        cfg_now = c;
    endtask

    // one slot: random gap, offer, hold until taken, then forecast its result
    task automatic offer_slot(input logic sv, input logic [7:0] sb,
                              input bit known, input res_t want);
        res_t outcome;
        while (!no_gaps && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        src_valid <= sv;
        src_byte  <= sb;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        outcome = predict_slot(sv, sb);
        slot_forecast.push_back(known ? want : outcome);
    endtask

    // mostly bytes that follow the keys, the rest breaks the sequences
    task automatic feed_items(input int want_items);
        int         n;
        bit         busy;
        logic       sv;
        logic [7:0] sb;
        n = 0;
        while (n < want_items)
        begin
            busy = (st_mode == MODE_INJECT) || (st_mode == MODE_HELD);
            sv   = ($urandom_range(99) < 85);
            if (busy)
                sb = 8'($urandom_range(255));
            else if ($urandom_range(99) < 85)
                sb = wanted_byte();
            else
                sb = any_byte();
            offer_slot(sv, sb, 1'b0, '0);
            // empty slots while searching are ignored by the block
            if (sv || busy)
                n++;
        end
    endtask

    // stop offering and let every outstanding transaction come back
    task automatic settle_block();
        in_valid <= 1'b0;
        while (slot_forecast.size() != 0)
            @(posedge clk);
    endtask

    task automatic note_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // sender side and run control
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int   cur_ph;
        int   held_mark;
        cfg_t big;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        src_valid <= 1'b0;
        src_byte  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed table, registers rewritten whenever the group changes
        cur_ph = 0;
        foreach (stim_table[r])
        begin
            if (stim_table[r].ph != cur_ph)
            begin
                settle_block();
                cur_ph = stim_table[r].ph;
                program_regs(directed_setting(cur_ph), 1'b0);
            end
            offer_slot(stim_table[r].sv, stim_table[r].sb, stim_table[r].known,
                       stim_table[r].want);
        end

        // random settings; slot state carries across so stale indexes recur
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle_block();
            narrow_bytes = ($urandom_range(2) == 0);
            program_regs(random_setting(), 1'(($urandom_range(1))));
            feed_items(35 + $urandom_range(10));
        end

        // finish any injection still running so the next one starts clean
        narrow_bytes = 1'b0;
        while (st_mode != MODE_SEARCH1)
            feed_items(1);

        // one long injection, full-width second key and pattern, no gaps
        settle_block();
        no_gaps = 1'b1;
        big                       = CFG_AT_RESET;
        big.first_key_bytes       = '0;
        big.first_key_length      = 4'd1;
        big.second_key_bytes      = '1;
        big.second_key_length     = 4'd8;
        big.inject_pattern_bytes  = 64'h0123_4567_89AB_CDEF;
        big.inject_pattern_length = 4'd8;
        big.inject_count          = 17'd40;
        program_regs(big, 1'b0);
        held_mark = held_count;
        while (held_count == held_mark)
            feed_items(1);
        feed_items(4);
        no_gaps = 1'b0;

        // drain, then leave room for any stray result
        settle_block();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver side: random stalls, one long hold-off, in-order checking
    // ------------------------------------------------------------------
    initial
    begin : result_side
        int   hold_left;
        int   seen;
        bit   pressure_done;
        res_t want;
        hold_left     = 0;
        seen          = 0;
        pressure_done = 1'b0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid === 1'b1 && !res_stall)
            begin
                seen++;
                if (slot_forecast.size() == 0)
                    note_mismatch("result with nothing pending", out_byte, 8'h00);
                else
                begin
                    want = slot_forecast.pop_front();
                    if (out_valid !== want.out_valid)
                        note_mismatch("out_valid", 8'(out_valid), 8'(want.out_valid));
                    if (out_byte !== want.out_byte)
                        note_mismatch("out_byte", out_byte, want.out_byte);
                    if (consumed !== want.consumed)
                        note_mismatch("consumed", 8'(consumed), 8'(want.consumed));
                end
            end
            // hold off for a long stretch once so the block backs up into its input
            if (!pressure_done && seen >= HOLD_OFF_AT)
            begin
                pressure_done = 1'b1;
                hold_left     = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
                res_stall <= !no_gaps && ($urandom_range(99) < 31);
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any transaction on either channel
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int idle_run;
        idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_stall === 1'b0) || (res_valid === 1'b1 && !res_stall))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule
